// File: design/dfrp_pkg.sv
package dfrp_pkg;

  localparam int RING_BYTES      = 524288;
  localparam int RING_AW         = $clog2(RING_BYTES);
  localparam int RING_GUARD      = 2;
  localparam int FIFO_DEPTH      = 1024;
  localparam int FIFO_AW         = $clog2(FIFO_DEPTH);
  localparam int MAX_CHUNK_BYTES = 128;
  localparam int MAX_WRITES      = MAX_CHUNK_BYTES / 2;
  localparam int WR_W            = $clog2(MAX_WRITES + 1);
  localparam int SAMPLE_W        = 16;
  localparam int CFG_LEN_W       = 20;
  localparam int CALC_W          = RING_AW + 2;
  localparam int STEP_W          = 32;
  localparam int FRAC_W          = 16;
  localparam int WANT_W          = STEP_W - FRAC_W;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);
  localparam int ADDR_W          = 4;
  localparam int DATA_W          = 32;
  localparam int REG_IDX_W       = 2;

  localparam logic [FIFO_AW-1:0] FIFO_MAX  = FIFO_AW'(FIFO_DEPTH - 1);
  localparam logic [CALC_W-1:0]  SPACE_LIM = CALC_W'(RING_BYTES - RING_GUARD);

  localparam logic                 RST_ENABLE = 1'b0;
  localparam logic [CFG_LEN_W-1:0] RST_TARGET = CFG_LEN_W'(1024);
  localparam logic [CFG_LEN_W-1:0] RST_MAX    = CFG_LEN_W'(1536);
  localparam logic [STEP_W-1:0]    RST_STEP   = STEP_W'(185759);

  localparam logic [REG_IDX_W-1:0] REG_ENABLE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_TARGET = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAX    = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_STEP   = 2'd3;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_PUMP = 1'b1;

  typedef enum logic {
    JOB_PUSH,
    JOB_PUMP
  } job_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_SIZE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic                       command;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [RING_AW-1:0]         read_pos;
  } item_t;

  typedef struct packed {
    logic [RING_AW-1:0]         ring_addr;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last;
    logic [RING_AW-1:0]         write_pos;
  } result_t;

  typedef struct packed {
    job_kind_t                  kind;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [RING_AW-1:0]         read_pos;
  } job_t;

  typedef struct packed {
    logic                 enable;
    logic [CFG_LEN_W-1:0] target_bytes;
    logic [CFG_LEN_W-1:0] max_bytes;
    logic [STEP_W-1:0]    resample_step;
  } cfg_t;

  // byte count halved, capped at the chunk limit in writes
  function automatic logic [WR_W-1:0] sat_half(input logic [CALC_W-1:0] v);
    logic [CALC_W-1:0] h;
    h = v >> 1;
    if (h > CALC_W'(MAX_WRITES)) begin
      return WR_W'(MAX_WRITES);
    end else begin
      return h[WR_W-1:0];
    end
  endfunction

endpackage

// File: design/dfrp_front.sv
module dfrp_front (
  input  logic             clk,
  input  logic             rst,
  input  dfrp_pkg::cfg_t   cfg,
  input  logic             item_valid,
  output logic             item_ready,
  input  dfrp_pkg::item_t  item,
  output logic             job_valid,
  input  logic             job_ready,
  output dfrp_pkg::job_t   job
);

  logic           held;
  logic           held_next;
  dfrp_pkg::job_t job_next;
  logic           take;
  logic           keep;

  assign item_ready = !held || job_ready;
  assign job_valid  = held;
  assign take       = item_valid && item_ready;
  // disabled pumps do nothing, drop them here
  assign keep       = (item.command == dfrp_pkg::CMD_PUSH) || cfg.enable;

  always_comb begin
    held_next = held;
    job_next  = job;
    if (held && job_ready) begin
      held_next = 1'b0;
    end
    if (take && keep) begin
      held_next          = 1'b1;
      job_next.kind      = (item.command == dfrp_pkg::CMD_PUSH) ? dfrp_pkg::JOB_PUSH
                                                                : dfrp_pkg::JOB_PUMP;
      job_next.sample_in = item.sample_in;
      job_next.read_pos  = item.read_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    job <= job_next;
  end

endmodule

// File: design/dfrp_queue.sv
module dfrp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  dfrp_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output dfrp_pkg::job_t pop_job
);

  dfrp_pkg::job_t                  slots [dfrp_pkg::QUEUE_DEPTH];
  logic [dfrp_pkg::QUEUE_AW-1:0]   wptr;
  logic [dfrp_pkg::QUEUE_AW-1:0]   rptr;
  logic [dfrp_pkg::QUEUE_AW:0]     fill;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = (fill != (dfrp_pkg::QUEUE_AW + 1)'(dfrp_pkg::QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_job    = slots[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_job;
    end
  end

endmodule

// File: design/dfrp_back.sv
module dfrp_back (
  input  logic              clk,
  input  logic              rst,
  input  dfrp_pkg::cfg_t    cfg,
  input  logic              job_valid,
  output logic              job_ready,
  input  dfrp_pkg::job_t    job,
  output logic              result_valid,
  input  logic              result_ready,
  output dfrp_pkg::result_t result
);

  logic [dfrp_pkg::SAMPLE_W-1:0] mem [dfrp_pkg::FIFO_DEPTH];
  logic [dfrp_pkg::SAMPLE_W-1:0] mem_q;

  dfrp_pkg::state_t               state, state_next;
  logic [dfrp_pkg::FIFO_AW-1:0]   head, head_next;
  logic [dfrp_pkg::FIFO_AW-1:0]   tail, tail_next;
  logic [dfrp_pkg::STEP_W-1:0]    acc, acc_next;
  logic [dfrp_pkg::RING_AW-1:0]   wr, wr_next;
  logic [dfrp_pkg::RING_AW-1:0]   used, used_next;
  logic [dfrp_pkg::WR_W-1:0]      t_tgt, t_tgt_next;
  logic [dfrp_pkg::WR_W-1:0]      t_max, t_max_next;
  logic [dfrp_pkg::WR_W-1:0]      t_space, t_space_next;
  logic [dfrp_pkg::WR_W-1:0]      t_fifo, t_fifo_next;
  logic [dfrp_pkg::WR_W-1:0]      rem, rem_next;
  logic                           pend_valid, pend_valid_next;
  logic [dfrp_pkg::RING_AW-1:0]   pend_addr, pend_addr_next;
  logic                           out_valid, out_valid_next;
  dfrp_pkg::result_t              out_data, out_data_next;

  logic [dfrp_pkg::FIFO_AW-1:0]   count;
  logic [dfrp_pkg::CALC_W-1:0]    used_w;
  logic [dfrp_pkg::CALC_W-1:0]    target_w;
  logic [dfrp_pkg::CALC_W-1:0]    max_w;
  logic [dfrp_pkg::STEP_W-1:0]    acc_sum;
  logic [dfrp_pkg::WANT_W-1:0]    want_raw;
  logic [dfrp_pkg::WANT_W-1:0]    want;
  logic [dfrp_pkg::STEP_W-1:0]    acc_after;
  logic                           enough;
  logic [dfrp_pkg::FIFO_AW-1:0]   rd_addr;
  logic                           rd_en;
  logic                           wr_en;
  logic                           out_free;
  logic                           go;
  logic                           flush;
  logic                           flush_last;
  logic [dfrp_pkg::WR_W-1:0]      m0;
  logic [dfrp_pkg::WR_W-1:0]      m1;

  assign count     = head - tail;
  assign used_w    = dfrp_pkg::CALC_W'(used);
  assign target_w  = dfrp_pkg::CALC_W'(cfg.target_bytes);
  assign max_w     = dfrp_pkg::CALC_W'(cfg.max_bytes);
  assign acc_sum   = acc + cfg.resample_step;
  assign want_raw  = acc_sum[dfrp_pkg::STEP_W-1:dfrp_pkg::FRAC_W];
  assign want      = (want_raw == '0) ? dfrp_pkg::WANT_W'(1) : want_raw;
  assign acc_after = (want_raw == '0) ? '0
                   : {dfrp_pkg::WANT_W'(0), acc_sum[dfrp_pkg::FRAC_W-1:0]};
  assign enough    = dfrp_pkg::WANT_W'(count) >= want;
  assign rd_addr   = tail + want[dfrp_pkg::FIFO_AW-1:0] - dfrp_pkg::FIFO_AW'(1);
  assign out_free  = !out_valid || result_ready;
  assign go        = !pend_valid || out_free;
  assign m0        = (t_tgt < t_max) ? t_tgt : t_max;
  assign m1        = (t_space < t_fifo) ? t_space : t_fifo;

  assign job_ready    = (state == dfrp_pkg::ST_IDLE);
  assign result_valid = out_valid;
  assign result       = out_data;

  always_comb begin
    state_next      = state;
    head_next       = head;
    tail_next       = tail;
    acc_next        = acc;
    wr_next         = wr;
    used_next       = used;
    t_tgt_next      = t_tgt;
    t_max_next      = t_max;
    t_space_next    = t_space;
    t_fifo_next     = t_fifo;
    rem_next        = rem;
    pend_valid_next = pend_valid;
    pend_addr_next  = pend_addr;
    rd_en           = 1'b0;
    wr_en           = 1'b0;
    flush           = 1'b0;
    flush_last      = 1'b0;

    unique case (state)
      dfrp_pkg::ST_IDLE: begin
        if (job_valid) begin
          if (job.kind == dfrp_pkg::JOB_PUSH) begin
            wr_en     = 1'b1;
            head_next = head + 1'b1;
            if (count == dfrp_pkg::FIFO_MAX) begin
              tail_next = tail + 1'b1;
            end
          end else begin
            used_next  = wr - job.read_pos;
            state_next = dfrp_pkg::ST_CLAMP;
          end
        end
      end
      dfrp_pkg::ST_CLAMP: begin
        t_tgt_next   = (used_w < target_w) ? dfrp_pkg::sat_half(target_w - used_w) : '0;
        t_max_next   = (used_w < max_w) ? dfrp_pkg::sat_half(max_w - used_w) : '0;
        t_space_next = (used_w <= dfrp_pkg::SPACE_LIM)
                     ? dfrp_pkg::sat_half(dfrp_pkg::SPACE_LIM - used_w) : '0;
        t_fifo_next  = dfrp_pkg::sat_half(dfrp_pkg::CALC_W'({count, 1'b0}));
        state_next   = dfrp_pkg::ST_SIZE;
      end
      dfrp_pkg::ST_SIZE: begin
        rem_next   = (m0 < m1) ? m0 : m1;
        state_next = dfrp_pkg::ST_RUN;
      end
      dfrp_pkg::ST_RUN: begin
        if (go) begin
          if (rem == '0) begin
            flush      = pend_valid;
            flush_last = 1'b1;
            state_next = dfrp_pkg::ST_IDLE;
          end else begin
            acc_next = acc_after;
            if (!enough) begin
              flush      = pend_valid;
              flush_last = 1'b1;
              state_next = dfrp_pkg::ST_IDLE;
            end else begin
              flush           = pend_valid;
              rd_en           = 1'b1;
              pend_addr_next  = wr;
              wr_next         = wr + dfrp_pkg::RING_AW'(2);
              tail_next       = tail + want[dfrp_pkg::FIFO_AW-1:0];
              rem_next        = rem - 1'b1;
            end
          end
          pend_valid_next = rd_en;
        end
      end
      default: begin
        state_next = dfrp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    out_data_next  = out_data;
    if (out_valid && result_ready) begin
      out_valid_next = 1'b0;
    end
    if (flush) begin
      out_valid_next           = 1'b1;
      out_data_next.ring_addr  = pend_addr;
      out_data_next.sample_out = mem_q;
      out_data_next.last       = flush_last;
      out_data_next.write_pos  = pend_addr + dfrp_pkg::RING_AW'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dfrp_pkg::ST_IDLE;
      head       <= '0;
      tail       <= '0;
      acc        <= '0;
      wr         <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      tail       <= tail_next;
      acc        <= acc_next;
      wr         <= wr_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    used      <= used_next;
    t_tgt     <= t_tgt_next;
    t_max     <= t_max_next;
    t_space   <= t_space_next;
    t_fifo    <= t_fifo_next;
    rem       <= rem_next;
    pend_addr <= pend_addr_next;
    out_data  <= out_data_next;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[head] <= job.sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

endmodule

// File: design/fifo_decimating_ring_pump.sv
// Push beat: passes the front register and the job queue, then is stored in the sample FIFO.
// Pump beat: passes the front register, the job queue and the engine's CLAMP and SIZE states;
// ring writes then follow at one write per cycle while result_ready holds, up to 64 writes.
// A 4-deep job queue lets input beats keep arriving while the engine runs.
// rst (synchronous) clears FIFO pointers, accumulator, write position and queues and
// loads register defaults; the sample store itself is not cleared.
module fifo_decimating_ring_pump (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  dfrp_pkg::item_t               item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output dfrp_pkg::result_t             result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dfrp_pkg::ADDR_W-1:0]   paddr,
  input  logic [dfrp_pkg::DATA_W-1:0]   pwdata,
  output logic [dfrp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  dfrp_pkg::cfg_t                 cfg;
  logic                           cfg_we;
  logic [dfrp_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           fj_valid;
  logic                           fj_ready;
  dfrp_pkg::job_t                 fj;
  logic                           bj_valid;
  logic                           bj_ready;
  dfrp_pkg::job_t                 bj;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[dfrp_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable        <= dfrp_pkg::RST_ENABLE;
      cfg.target_bytes  <= dfrp_pkg::RST_TARGET;
      cfg.max_bytes     <= dfrp_pkg::RST_MAX;
      cfg.resample_step <= dfrp_pkg::RST_STEP;
    end else if (cfg_we) begin
      unique case (reg_idx)
        dfrp_pkg::REG_ENABLE: cfg.enable        <= pwdata[0];
        dfrp_pkg::REG_TARGET: cfg.target_bytes  <= pwdata[dfrp_pkg::CFG_LEN_W-1:0];
        dfrp_pkg::REG_MAX:    cfg.max_bytes     <= pwdata[dfrp_pkg::CFG_LEN_W-1:0];
        dfrp_pkg::REG_STEP:   cfg.resample_step <= pwdata[dfrp_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      dfrp_pkg::REG_ENABLE: prdata = dfrp_pkg::DATA_W'(cfg.enable);
      dfrp_pkg::REG_TARGET: prdata = dfrp_pkg::DATA_W'(cfg.target_bytes);
      dfrp_pkg::REG_MAX:    prdata = dfrp_pkg::DATA_W'(cfg.max_bytes);
      dfrp_pkg::REG_STEP:   prdata = dfrp_pkg::DATA_W'(cfg.resample_step);
      default:              prdata = '0;
    endcase
  end

  dfrp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .job_valid  (fj_valid),
    .job_ready  (fj_ready),
    .job        (fj)
  );

  dfrp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fj_valid),
    .push_ready (fj_ready),
    .push_job   (fj),
    .pop_valid  (bj_valid),
    .pop_ready  (bj_ready),
    .pop_job    (bj)
  );

  dfrp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .job_valid    (bj_valid),
    .job_ready    (bj_ready),
    .job          (bj),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// File: design/dfrp_checker.sv
module dfrp_checker (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_ready,
  input dfrp_pkg::result_t result
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  a_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result beat right after reset");

  a_wpos: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.write_pos == (result.ring_addr + 19'd2))
    else $error("write_pos does not follow ring_addr");

  a_even: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !result.ring_addr[0])
    else $error("odd ring address");

endmodule

bind fifo_decimating_ring_pump dfrp_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

// File: verif/ring_write_checker.sv
module ring_write_checker
  import dfrp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_ready,
  input  item_t               item,
  input  logic                result_valid,
  input  logic                result_ready,
  input  result_t             result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output int unsigned         mismatches,
  output int unsigned         writes_pending,
  output logic [RING_AW-1:0]  ring_pos
);

  logic [SAMPLE_W-1:0] fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  head;
  logic [FIFO_AW-1:0]  tail;
  logic [STEP_W-1:0]   acc;
  logic [RING_AW-1:0]  wpos;
  cfg_t                cfg;
  result_t             ring_writes [$];

  initial begin
    mismatches     = 0;
    writes_pending = 0;
    ring_pos       = '0;
  end

  function automatic int fifo_level();
    return int'(FIFO_AW'(head - tail));
  endfunction

  task automatic flag(input string field, input logic [31:0] want_v, input logic [31:0] got_v);
    mismatches++;
    $error("%s: expected %0h, got %0h", field, want_v, got_v);
  endtask

  task automatic check_write(input result_t got);
    result_t want_w;
    if (ring_writes.size() == 0) begin
      mismatches++;
      $error("ring write: expected none, got addr %0h data %0h", got.ring_addr,
             got.sample_out);
      return;
    end
    want_w = ring_writes.pop_front();
    if (got.ring_addr !== want_w.ring_addr) begin
      flag("ring_addr", 32'(want_w.ring_addr), 32'(got.ring_addr));
    end
    if (got.sample_out !== want_w.sample_out) begin
      flag("sample_out", 32'(want_w.sample_out), 32'(got.sample_out));
    end
    if (got.last !== want_w.last) flag("last", 32'(want_w.last), 32'(got.last));
    if (got.write_pos !== want_w.write_pos) begin
      flag("write_pos", 32'(want_w.write_pos), 32'(got.write_pos));
    end
  endtask

  // one input beat: FIFO push, or a pump that may queue ring writes
  task automatic take_beat(input item_t beat);
    int                  rd;
    int                  wrv;
    int                  used;
    int                  space;
    int                  budget;
    int                  want;
    int                  i;
    int                  k;
    logic [STEP_W-1:0]   dec;
    logic [SAMPLE_W-1:0] picked;
    logic [RING_AW-1:0]  wr;
    result_t             w;
    result_t             held;
    bit                  have_held;
    if (beat.command == CMD_PUSH) begin
      if (fifo_level() >= FIFO_DEPTH - 1) tail = tail + 1'b1;
      fifo_mem[head] = beat.sample_in;
      head = head + 1'b1;
      return;
    end
    if (!cfg.enable) return;
    wr    = wpos;
    rd    = int'(beat.read_pos);
    wrv   = int'(wpos);
    used  = (wrv >= rd) ? wrv - rd : RING_BYTES - rd + wrv;
    space = (RING_BYTES - used >= RING_GUARD) ? RING_BYTES - used - RING_GUARD : 0;
    if (used >= int'(cfg.target_bytes)) return;
    budget = int'(cfg.target_bytes) - used;
    if (budget > 2 * fifo_level()) budget = 2 * fifo_level();
    if (used + budget > int'(cfg.max_bytes)) begin
      budget = (int'(cfg.max_bytes) > used) ? int'(cfg.max_bytes) - used : 0;
    end
    if (budget > space) budget = space;
    if (budget > MAX_CHUNK_BYTES) budget = MAX_CHUNK_BYTES;
    budget = budget & ~1;
    have_held = 1'b0;
    picked    = '0;
    for (i = 0; i < budget; i += 2) begin
      acc  = acc + cfg.resample_step;
      want = int'(acc[STEP_W-1:FRAC_W]);
      if (want == 0) want = 1;
      dec = STEP_W'(want) << FRAC_W;
      acc = (acc >= dec) ? acc - dec : '0;
      if (fifo_level() < want) break;
      for (k = 0; k < want; k++) begin
        picked = fifo_mem[tail];
        tail   = tail + 1'b1;
      end
      w.ring_addr  = wr;
      w.sample_out = picked;
      w.last       = 1'b0;
      wr           = wr + RING_AW'(2);
      w.write_pos  = wr;
      if (have_held) ring_writes.push_back(held);
      held      = w;
      have_held = 1'b1;
    end
    if (have_held) begin
      held.last = 1'b1;
      ring_writes.push_back(held);
    end
    wpos = wr;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      head = '0;
      tail = '0;
      acc  = '0;
      wpos = '0;
      cfg  = '{enable: RST_ENABLE, target_bytes: RST_TARGET, max_bytes: RST_MAX,
               resample_step: RST_STEP};
      ring_writes.delete();
    end else begin
      if (result_valid && result_ready) check_write(result);
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_ENABLE: cfg.enable        = pwdata[0];
          REG_TARGET: cfg.target_bytes  = pwdata[CFG_LEN_W-1:0];
          REG_MAX:    cfg.max_bytes     = pwdata[CFG_LEN_W-1:0];
          REG_STEP:   cfg.resample_step = pwdata[STEP_W-1:0];
          default: ;
        endcase
      end
      if (item_valid && item_ready) take_beat(item);
    end
    writes_pending = ring_writes.size();
    ring_pos       = wpos;
  end

endmodule

// File: verif/fifo_decimating_ring_pump_test.sv
module fifo_decimating_ring_pump_test;
  import dfrp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ENGINE_DRAIN   = 64;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_ready;
  item_t              item = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  result_t            result;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  int unsigned        fail_count;
  int unsigned        writes_pending;
  logic [RING_AW-1:0] ring_pos;
  int                 sender_idle_pct = 0;
  int                 receiver_stall_pct = 0;
  int                 quiet_cycles = 0;

  always #10 clk = ~clk;

  fifo_decimating_ring_pump u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  ring_write_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item           (item),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result         (result),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .mismatches     (fail_count),
    .writes_pending (writes_pending),
    .ring_pos       (ring_pos)
  );

  always @(negedge clk) begin
    result_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("fifo_decimating_ring_pump regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // relative: read_pos holds a distance behind the predicted write position
  task automatic send_beat(input item_t beat, input bit relative);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    if (relative) beat.read_pos = ring_pos - beat.read_pos;
    item_valid <= 1'b1;
    item       <= beat;
    do @(posedge clk); while (!item_ready);
  endtask

  task automatic push(input logic [SAMPLE_W-1:0] smp);
    item_t beat;
    beat.command   = CMD_PUSH;
    beat.sample_in = smp;
    beat.read_pos  = RING_AW'($urandom);
    send_beat(beat, 1'b0);
  endtask

  task automatic push_random(input int count);
    repeat (count) push(SAMPLE_W'($urandom));
  endtask

  task automatic pump(input logic [RING_AW-1:0] pos, input bit relative);
    item_t beat;
    beat.command   = CMD_PUMP;
    beat.sample_in = SAMPLE_W'($urandom);
    beat.read_pos  = pos;
    send_beat(beat, relative);
  endtask

  task automatic pump_back(input logic [RING_AW-1:0] back);
    pump(back, 1'b1);
  endtask

  task automatic settle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (writes_pending != 0) @(negedge clk);
    repeat (ENGINE_DRAIN) @(negedge clk);
  endtask

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(input logic en, input int unsigned tgt, input int unsigned mx,
                           input logic [STEP_W-1:0] stp);
    reg_write(REG_ENABLE, DATA_W'(en));
    reg_write(REG_TARGET, DATA_W'(tgt));
    reg_write(REG_MAX, DATA_W'(mx));
    reg_write(REG_STEP, stp);
  endtask

  task automatic random_traffic(input int beats);
    int sent;
    int burst;
    int pick;
    sent = 0;
    while (sent < beats) begin
      burst = $urandom_range(0, 12);
      push_random(burst);
      pick = $urandom_range(99);
      if (pick < 70) pump_back(RING_AW'($urandom_range(0, 256)));
      else if (pick < 85) pump_back(RING_AW'($urandom_range(0, 4096)));
      else pump(RING_AW'($urandom), 1'b0);
      sent += burst + 1;
    end
  endtask

  task automatic random_phase(input int s_pct, input int r_pct);
    int unsigned tgt;
    settle();
    sender_idle_pct    = s_pct;
    receiver_stall_pct = r_pct;
    tgt = $urandom_range(64, 2048);
    configure($urandom_range(9) != 0, tgt, tgt + $urandom_range(0, 512),
              STEP_W'($urandom_range(32'h4000, 32'h38000)));
    random_traffic(24);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // sample extremes, pump while disabled
    reg_write(REG_ENABLE, DATA_W'(0));
    push(16'h7FFF);
    push(16'h8000);
    push(16'h0000);
    push(16'hFFFF);
    push(16'h5555);
    push(16'hAAAA);
    pump_back('0);
    settle();
    reg_write(REG_ENABLE, DATA_W'(1));
    pump_back('0);                        // runs short of samples mid-pump
    push_random(4);
    pump_back(RING_AW'(1024));            // at target
    pump_back(RING_AW'(RING_BYTES - 1));  // ring nearly full
    settle();
    reg_write(REG_TARGET, DATA_W'(RING_BYTES));
    reg_write(REG_MAX, DATA_W'(RING_BYTES));
    reg_write(REG_STEP, DATA_W'(32'h8000));
    pump_back(RING_AW'(RING_BYTES - 1));  // inside the guard
    pump_back('0);                        // step below one
    push_random(4);
    settle();
    reg_write(REG_MAX, DATA_W'(16));
    pump_back(RING_AW'(100));             // max below occupancy
    pump_back('0);
    settle();
    reg_write(REG_TARGET, DATA_W'(0));
    push_random(3);
    pump_back('0);
    settle();
    configure(1'b1, 1024, 1536, '1);
    pump_back('0);                        // huge step, nothing written
    settle();
    reg_write(REG_STEP, '0);
    pump_back('0);

    random_phase(0, 0);
    random_phase(57, 0);
    random_phase(0, 57);
    random_phase(16, 16);

    settle();
    if (fail_count == 0) begin
      $display("fifo_decimating_ring_pump regression: pass");
    end else begin
      $display("fifo_decimating_ring_pump regression: fail");
    end
    $finish;
  end

endmodule

// File: fifo_decimating_ring_pump.f
design/dfrp_pkg.sv
design/dfrp_front.sv
design/dfrp_queue.sv
design/dfrp_back.sv
design/fifo_decimating_ring_pump.sv
design/dfrp_checker.sv
verif/ring_write_checker.sv
verif/fifo_decimating_ring_pump_test.sv
